### rtl/sliding_window_quality_check_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers for the sliding window quality check unit
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_QUALITY_CHECK_UNIT_ASSERT_SVH
`define SLIDING_WINDOW_QUALITY_CHECK_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// assertion on an explicit clock and active-low reset
`define SWQC_ASSERT_ON(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("swqc assertion failed");
// assertion on the usual clk_i / rst_ni pair
`define SWQC_ASSERT(lbl, prop) `SWQC_ASSERT_ON(lbl, clk_i, rst_ni, prop)
`else
`define SWQC_ASSERT_ON(lbl, clk, rstn, prop)
`define SWQC_ASSERT(lbl, prop)
`endif

`endif

### rtl/swqc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swqc_pkg
// Shared widths, register codes and types of the sliding window quality check
// ----------------------------------------------------------------------------
package swqc_pkg;

  localparam int unsigned SWQC_WINDOW_MAX      = 64;
  localparam int unsigned SWQC_MAX_READ_LENGTH = 65536;

  localparam int unsigned QUAL_W     = 8;
  localparam int unsigned POS_W      = 16;
  localparam int unsigned SUM_W      = 14;
  localparam int unsigned CFG_WIN_W  = 7;
  localparam int unsigned CFG_STEP_W = 7;
  localparam int unsigned MIN_AVG_W  = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WINDOW_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_STEP_SIZE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MIN_AVERAGE = 2'd2;

  localparam logic [CFG_WIN_W-1:0]  WINDOW_SIZE_RST = 7'd50;
  localparam logic [CFG_STEP_W-1:0] STEP_SIZE_RST   = 7'd5;
  localparam logic [MIN_AVG_W-1:0]  MIN_AVERAGE_RST = 8'd20;

  typedef struct packed {
    logic [CFG_WIN_W-1:0]  window_size;
    logic [CFG_STEP_W-1:0] step_size;
    logic [MIN_AVG_W-1:0]  min_average;
  } swqc_cfg_t;

  typedef struct packed {
    logic             passed;
    logic [POS_W-1:0] position;
  } swqc_result_t;

endpackage

### rtl/swqc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swqc_in_if
// Input stream of quality scores with a last flag
// ----------------------------------------------------------------------------
interface swqc_in_if
  import swqc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [QUAL_W-1:0] quality;
  logic              last;

  modport source (output valid, output quality, output last, input ready);
  modport sink   (input valid, input quality, input last, output ready);
endinterface

### rtl/swqc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swqc_out_if
// Result stream: pass flag and position, one item per read
// ----------------------------------------------------------------------------
interface swqc_out_if
  import swqc_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             passed;
  logic [POS_W-1:0] position;

  modport source (output valid, output passed, output position, input ready);
  modport sink   (input valid, input passed, input position, output ready);
endinterface

### rtl/swqc_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swqc_ring
// Score ring memory with registered read and write-to-read bypass
// ----------------------------------------------------------------------------
module swqc_ring
  import swqc_pkg::*;
#(
  parameter int unsigned DEPTH = SWQC_WINDOW_MAX
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [QUAL_W-1:0]        wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [QUAL_W-1:0]        rd_data_o
);
  logic [QUAL_W-1:0] mem [DEPTH];
  logic [QUAL_W-1:0] rd_q;
  logic [QUAL_W-1:0] byp_data_q;
  logic              byp_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_q       <= mem[rd_addr_i];
    byp_data_q <= wr_data_i;
  end

  // read of the slot written in the same cycle takes the new score
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else begin
      byp_q <= wr_en_i && (rd_addr_i == wr_addr_i);
    end
  end

  assign rd_data_o = byp_q ? byp_data_q : rd_q;
endmodule

### rtl/swqc_window.sv
`timescale 1ns / 1ps
`include "sliding_window_quality_check_unit_assert.svh"
// ----------------------------------------------------------------------------
// swqc_window
// Running window sum, window test, failure latch and per-read result
// ----------------------------------------------------------------------------
module swqc_window
  import swqc_pkg::*;
#(
  parameter int unsigned WINDOW_MAX      = SWQC_WINDOW_MAX,
  parameter int unsigned MAX_READ_LENGTH = SWQC_MAX_READ_LENGTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  swqc_cfg_t         cfg_i,
  input  logic              acc_i,
  input  logic [QUAL_W-1:0] quality_i,
  input  logic              last_i,
  output swqc_result_t      res_o
);
  localparam int unsigned PTRW = $clog2(WINDOW_MAX);
  localparam int unsigned RW   = $clog2(WINDOW_MAX + 1);
  localparam int unsigned CW   = (RW > CFG_WIN_W) ? RW : CFG_WIN_W;
  localparam int unsigned IW   = $clog2(MAX_READ_LENGTH);
  localparam int unsigned EW   = ((IW > RW) ? IW : RW) + 1;
  localparam int unsigned THW  = MIN_AVG_W + RW;
  localparam int unsigned CMPW = (THW > SUM_W) ? THW : SUM_W;
  localparam int unsigned PW   = (IW > POS_W) ? IW : POS_W;

  localparam logic [IW-1:0]   LIMIT    = IW'(MAX_READ_LENGTH - 1);
  localparam logic [PTRW-1:0] PTR_LAST = PTRW'(WINDOW_MAX - 1);
  localparam logic [PTRW:0]   DEPTH_X  = (PTRW + 1)'(WINDOW_MAX);

  logic [SUM_W-1:0] sum_q, sum_d;
  logic [IW-1:0]    idx_q, idx_d;
  logic [IW-1:0]    nws_q, nws_d;
  logic [IW-1:0]    fail_start_q, fail_start_d;
  logic             failed_q, failed_d;
  logic [PTRW-1:0]  ptr_q, ptr_d;

  logic [CW-1:0]         win_raw;
  logic [RW-1:0]         win;
  logic [CFG_STEP_W-1:0] step;
  logic [THW-1:0]        thr;
  logic                  at_limit;
  logic                  ge_w;
  logic                  hit;
  logic                  fail_now;
  logic [EW-1:0]         nx;
  logic [IW-1:0]         nx_sat;
  logic [QUAL_W-1:0]     rd_data;
  logic [QUAL_W-1:0]     old;
  logic [SUM_W-1:0]      sum_new;
  logic [PTRW:0]         rd_ext;
  logic [PTRW:0]         rd_full;
  logic [PTRW-1:0]       rd_addr;
  logic                  fails;
  logic [IW-1:0]         fpos;
  logic [PW-1:0]         pos_wide;

  // effective settings: zero acts as one, window clamps to the ring depth
  assign win_raw = CW'(cfg_i.window_size);
  assign win     = (win_raw == '0) ? RW'(1) :
                   (win_raw > CW'(WINDOW_MAX)) ? RW'(WINDOW_MAX) : win_raw[RW-1:0];
  assign step    = (cfg_i.step_size == '0) ? CFG_STEP_W'(1) : cfg_i.step_size;
  assign thr     = THW'(cfg_i.min_average) * THW'(win);

  assign at_limit = (idx_q == LIMIT);
  assign ge_w     = (EW'(idx_q) >= EW'(win));
  // window starting at nws_q is tested when the score just after it arrives
  assign hit      = !failed_q && ge_w && !at_limit &&
                    (EW'(idx_q) == EW'(nws_q) + EW'(win));
  assign fail_now = hit && (CMPW'(sum_q) < CMPW'(thr));
  assign nx       = EW'(nws_q) + EW'(step);
  assign nx_sat   = (nx > EW'(LIMIT)) ? LIMIT : nx[IW-1:0];

  assign old     = ge_w ? rd_data : '0;
  assign sum_new = sum_q - SUM_W'(old) + SUM_W'(quality_i);

  always_comb begin
    sum_d        = sum_q;
    idx_d        = idx_q;
    nws_d        = nws_q;
    fail_start_d = fail_start_q;
    failed_d     = failed_q;
    ptr_d        = ptr_q;
    if (acc_i) begin
      if (last_i) begin
        sum_d        = '0;
        idx_d        = '0;
        nws_d        = '0;
        fail_start_d = '0;
        failed_d     = 1'b0;
        ptr_d        = '0;
      end else begin
        sum_d = sum_new;
        if (fail_now) begin
          failed_d     = 1'b1;
          fail_start_d = nws_q;
        end else if (hit) begin
          nws_d = nx_sat;
        end
        if (!at_limit) begin
          idx_d = idx_q + 1'b1;
          ptr_d = (ptr_q == PTR_LAST) ? '0 : ptr_q + 1'b1;
        end
      end
    end
  end

  // prefetch the slot that drops out of the window for the next item
  assign rd_ext  = {1'b0, ptr_d};
  assign rd_full = (rd_ext >= (PTRW + 1)'(win)) ? (rd_ext - (PTRW + 1)'(win))
                                                : (rd_ext + DEPTH_X - (PTRW + 1)'(win));
  assign rd_addr = rd_full[PTRW-1:0];

  swqc_ring #(
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (acc_i),
    .wr_addr_i (ptr_q),
    .wr_data_i (quality_i),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q        <= '0;
      idx_q        <= '0;
      nws_q        <= '0;
      fail_start_q <= '0;
      failed_q     <= 1'b0;
      ptr_q        <= '0;
    end else begin
      sum_q        <= sum_d;
      idx_q        <= idx_d;
      nws_q        <= nws_d;
      fail_start_q <= fail_start_d;
      failed_q     <= failed_d;
      ptr_q        <= ptr_d;
    end
  end

  // a failure found on the last item itself still counts
  assign fails    = failed_q || fail_now;
  assign fpos     = fail_now ? nws_q : fail_start_q;
  assign pos_wide = PW'(fails ? fpos : idx_q);

  assign res_o.passed   = !fails;
  assign res_o.position = pos_wide[POS_W-1:0];

  `SWQC_ASSERT(a_clear_on_last, (acc_i && last_i) |=> (idx_q == '0 && !failed_q && ptr_q == '0))
  `SWQC_ASSERT(a_fail_sticky, (failed_q && !(acc_i && last_i)) |=> failed_q)
  `SWQC_ASSERT(a_index_step, (acc_i && !last_i && !at_limit) |=> (idx_q == IW'($past(idx_q) + 1'b1)))
  `SWQC_ASSERT(a_start_frozen, (failed_q && !acc_i) |=> $stable(nws_q) && $stable(fail_start_q))
endmodule

### rtl/sliding_window_quality_check_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_quality_check_unit
// Sliding window quality check over one read of quality scores at a time
// ----------------------------------------------------------------------------
// in_i carries one quality score per item, with last marking the end of a read.
// out_o carries one item per read: passed, and position (read length minus one
// if every tested window passed, else the start of the first failing window).
// Throughput is one score per cycle unless in_i is held off: the window sum,
// the window test and the ring update are done in the same cycle, with the
// dropped score prefetched from the ring memory in the cycle before through
// its registered read port. The result appears on out_o the cycle after the
// last score is taken. A single output register holds the result; while it is
// full and out_o is stalled, in_i is held off, otherwise scores keep flowing.
// Configuration (window size, step size, minimum average) is written through
// cfg_we_i / cfg_idx_i / cfg_data_i while no read is in progress.
// Reset clears all per-read state and loads the default settings; the ring
// needs no clearing pass, as only slots written in the current read are read.
// ----------------------------------------------------------------------------
module sliding_window_quality_check_unit
  import swqc_pkg::*;
#(
  parameter int unsigned WINDOW_MAX      = SWQC_WINDOW_MAX,
  parameter int unsigned MAX_READ_LENGTH = SWQC_MAX_READ_LENGTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  swqc_in_if.sink               in_i,
  swqc_out_if.source            out_o
);
  swqc_cfg_t    cfg_q;
  swqc_result_t res;
  swqc_result_t out_res_q;
  logic         out_valid_q;
  logic         acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_size <= WINDOW_SIZE_RST;
      cfg_q.step_size   <= STEP_SIZE_RST;
      cfg_q.min_average <= MIN_AVERAGE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IDX_WINDOW_SIZE: cfg_q.window_size <= cfg_data_i[CFG_WIN_W-1:0];
        CFG_IDX_STEP_SIZE:   cfg_q.step_size   <= cfg_data_i[CFG_STEP_W-1:0];
        CFG_IDX_MIN_AVERAGE: cfg_q.min_average <= cfg_data_i[MIN_AVG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign acc        = in_i.valid && in_i.ready;

  swqc_window #(
    .WINDOW_MAX      (WINDOW_MAX),
    .MAX_READ_LENGTH (MAX_READ_LENGTH)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .acc_i     (acc),
    .quality_i (in_i.quality),
    .last_i    (in_i.last),
    .res_o     (res)
  );

  // result item is loaded on the last score of a read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (acc && in_i.last) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && in_i.last) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.passed   = out_res_q.passed;
  assign out_o.position = out_res_q.position;
endmodule

### bench/swqc_verdict_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swqc_verdict_checker
// Watches the score and verdict streams of the quality check unit, predicts
// the verdict of every read from the accepted scores and compares it, field
// by field, with what the block returns
// ----------------------------------------------------------------------------
module swqc_verdict_checker
  import swqc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [QUAL_W-1:0]     in_quality_i,
  input  logic                  in_last_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic                  out_passed_i,
  input  logic [POS_W-1:0]      out_position_i,
  output int unsigned           due_count_o,
  output int unsigned           error_count_o
);

  localparam int unsigned IDX_CAP = SWQC_MAX_READ_LENGTH - 1;

  // shadow copy of the settings and of the per-read state
  logic [CFG_WIN_W-1:0]  win_reg;
  logic [CFG_STEP_W-1:0] step_reg;
  logic [MIN_AVG_W-1:0]  min_reg;

  logic [QUAL_W-1:0] score_hist [SWQC_WINDOW_MAX];
  logic [SUM_W-1:0]  run_sum;
  logic [POS_W-1:0]  base_idx;
  logic [POS_W-1:0]  next_start;
  logic [POS_W-1:0]  fail_pos;
  logic              fail_seen;

  swqc_result_t verdicts_due [$];

  function automatic void clear_read();
    run_sum    = '0;
    base_idx   = '0;
    next_start = '0;
    fail_pos   = '0;
    fail_seen  = 1'b0;
  endfunction

  // advances the read by one score; returns 1 when a verdict is due
  function automatic bit take_score(input logic [QUAL_W-1:0] q, input logic last_f);
    int unsigned  w;
    int unsigned  st;
    int unsigned  i;
    int unsigned  nx;
    swqc_result_t verdict;
    w  = (win_reg == 0) ? 1 : ((win_reg > SWQC_WINDOW_MAX) ? SWQC_WINDOW_MAX : win_reg);
    st = (step_reg == 0) ? 1 : step_reg;
    i  = base_idx;

    // window ending just before this score
    if (!fail_seen && i >= w && i < IDX_CAP && (i - w) == next_start) begin
      if (run_sum < min_reg * w) begin
        fail_seen = 1'b1;
        fail_pos  = next_start;
      end else begin
        nx         = next_start + st;
        next_start = (nx > IDX_CAP) ? IDX_CAP[POS_W-1:0] : nx[POS_W-1:0];
      end
    end

    if (i >= w) run_sum = run_sum - score_hist[(i - w) % SWQC_WINDOW_MAX];
    score_hist[i % SWQC_WINDOW_MAX] = q;
    run_sum = run_sum + q;

    if (last_f) begin
      verdict.passed   = !fail_seen;
      verdict.position = fail_seen ? fail_pos : i[POS_W-1:0];
      verdicts_due = {verdicts_due, verdict};
      clear_read();
      return 1'b1;
    end
    if (i < IDX_CAP) base_idx = i + 1;
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track_streams
    int unsigned  errs;
    bit           pushed;
    bit           popped;
    swqc_result_t due;
    if (!rst_ni) begin
      clear_read();
      foreach (score_hist[n]) score_hist[n] = '0;
      win_reg  = WINDOW_SIZE_RST;
      step_reg = STEP_SIZE_RST;
      min_reg  = MIN_AVERAGE_RST;
      verdicts_due.delete();
      due_count_o   <= 0;
      error_count_o <= 0;
    end else begin
      errs   = 0;
      pushed = 1'b0;
      popped = 1'b0;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_IDX_WINDOW_SIZE: win_reg  = cfg_data_i[CFG_WIN_W-1:0];
          CFG_IDX_STEP_SIZE:   step_reg = cfg_data_i[CFG_STEP_W-1:0];
          CFG_IDX_MIN_AVERAGE: min_reg  = cfg_data_i[MIN_AVG_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_i && out_ready_i) begin
        if (verdicts_due.size() == 0) begin
          $error("verdict with none due: passed %0d, position %0d",
                 out_passed_i, out_position_i);
          errs++;
        end else begin
          due    = verdicts_due.pop_front();
          popped = 1'b1;
          if (out_passed_i !== due.passed) begin
            $error("passed: expected %0d, actual %0d", due.passed, out_passed_i);
            errs++;
          end
          if (out_position_i !== due.position) begin
            $error("position: expected %0d, actual %0d", due.position, out_position_i);
            errs++;
          end
        end
      end

      if (in_valid_i && in_ready_i) pushed = take_score(in_quality_i, in_last_i);

      due_count_o   <= due_count_o + pushed - popped;
      error_count_o <= error_count_o + errs;
    end
  end

endmodule

### bench/tb_sliding_window_quality_check_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sliding_window_quality_check_unit
// Drives reads of quality scores through the quality check unit under a
// range of window, step and threshold settings, with random gaps on the
// score stream and random stalls on the verdict stream, and reports the
// outcome of the verdict checker
// ----------------------------------------------------------------------------
module tb_sliding_window_quality_check_unit;
  import swqc_pkg::*;

  localparam int unsigned CLK_PERIOD    = 12;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned PHASE_ITEMS   = 450;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx    = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  logic                  tx_valid   = 1'b0;
  logic [QUAL_W-1:0]     tx_quality = '0;
  logic                  tx_last    = 1'b0;
  logic                  rx_ready   = 1'b0;

  int unsigned gap_pct     = 0;
  int unsigned stall_pct   = 0;
  int unsigned items_sent  = 0;
  int unsigned cur_win     = 50;
  int          cur_min     = 20;
  int unsigned due_count;
  int unsigned error_count;

  swqc_in_if  score_if ();
  swqc_out_if verdict_if ();

  assign score_if.valid   = tx_valid;
  assign score_if.quality = tx_quality;
  assign score_if.last    = tx_last;
  assign verdict_if.ready = rx_ready;

  sliding_window_quality_check_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (score_if),
    .out_o      (verdict_if)
  );

  swqc_verdict_checker verdict_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (score_if.valid),
    .in_ready_i     (score_if.ready),
    .in_quality_i   (score_if.quality),
    .in_last_i      (score_if.last),
    .out_valid_i    (verdict_if.valid),
    .out_ready_i    (verdict_if.ready),
    .out_passed_i   (verdict_if.passed),
    .out_position_i (verdict_if.position),
    .due_count_o    (due_count),
    .error_count_o  (error_count)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) rx_ready <= ($urandom_range(99) >= stall_pct);

  task automatic send_score(input logic [QUAL_W-1:0] q, input logic last_f);
    while ($urandom_range(99) < gap_pct) begin
      tx_valid <= 1'b0;
      @(posedge clk_i);
    end
    tx_valid   <= 1'b1;
    tx_quality <= q;
    tx_last    <= last_f;
    do @(posedge clk_i); while (!score_if.ready);
    items_sent++;
  endtask

  // sender holds off until every verdict due has come out
  task automatic settle();
    tx_valid <= 1'b0;
    @(posedge clk_i);
    while (due_count != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_settings(input logic [CFG_DATA_W-1:0] w, s, m);
    settle();
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_IDX_WINDOW_SIZE;
    cfg_data <= w;
    @(posedge clk_i);
    cfg_idx  <= CFG_IDX_STEP_SIZE;
    cfg_data <= s;
    @(posedge clk_i);
    cfg_idx  <= CFG_IDX_MIN_AVERAGE;
    cfg_data <= m;
    @(posedge clk_i);
    cfg_idx  <= CFG_IDX_SPARE;
    cfg_data <= CFG_DATA_W'($urandom);
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    cur_win = (w[6:0] == 0) ? 1 : ((w[6:0] > SWQC_WINDOW_MAX) ? SWQC_WINDOW_MAX : w[6:0]);
    cur_min = m;
  endtask

  task automatic random_settings();
    logic [6:0]            w;
    logic [6:0]            s;
    logic [CFG_DATA_W-1:0] m;
    case ($urandom_range(9))
      0:       w = 7'd1;
      1:       w = 7'd2;
      2:       w = 7'd64;
      3:       w = 7'd0;
      4:       w = 7'($urandom_range(65, 127));
      5, 6:    w = 7'($urandom_range(1, 64));
      default: w = 7'($urandom_range(1, 12));
    endcase
    case ($urandom_range(7))
      0:       s = 7'd1;
      1:       s = 7'd0;
      2:       s = 7'd64;
      3:       s = 7'($urandom_range(65, 127));
      default: s = 7'($urandom_range(1, 8));
    endcase
    case ($urandom_range(7))
      0:       m = 8'd0;
      1:       m = 8'd255;
      default: m = CFG_DATA_W'($urandom_range(5, 60));
    endcase
    // top bit of the 7-bit registers is dropped by the block
    load_settings({1'($urandom_range(1)), w}, {1'($urandom_range(1)), s}, m);
  endtask

  function automatic logic [QUAL_W-1:0] pick_quality(input int center);
    int v;
    if ($urandom_range(19) == 0) return QUAL_W'($urandom_range(255));
    v = center + int'($urandom_range(20)) - 10;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[QUAL_W-1:0];
  endfunction

  task automatic send_read(input int unsigned len);
    int center;
    center = cur_min + int'($urandom_range(40)) - 12;
    for (int unsigned k = 0; k < len; k++) send_score(pick_quality(center), k == len - 1);
  endtask

  initial begin
    #(20_000_000);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings, read too short for any window
    send_score(8'd0, 1'b0);
    send_score(8'd255, 1'b0);
    send_score(8'd20, 1'b1);
    // second window fails
    load_settings(8'd2, 8'd1, 8'd10);
    send_score(8'd255, 1'b0);
    send_score(8'd0, 1'b0);
    send_score(8'd0, 1'b0);
    send_score(8'd255, 1'b1);
    // single-score read
    send_score(8'd7, 1'b1);
    // zero window and step act as one, highest threshold
    load_settings(8'd0, 8'd0, 8'd255);
    send_score(8'd255, 1'b0);
    send_score(8'd255, 1'b0);
    send_score(8'd254, 1'b0);
    send_score(8'd255, 1'b1);
    // oversized window clamps to the ring depth
    load_settings(8'hFF, 8'd64, 8'd0);
    send_score(8'd0, 1'b0);
    send_score(8'd0, 1'b0);
    send_score(8'd0, 1'b1);
    // zero threshold never fails
    load_settings(8'd1, 8'd1, 8'd0);
    send_score(8'd0, 1'b0);
    send_score(8'd0, 1'b1);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       begin gap_pct = 0;  stall_pct <= 0;  end
        1:       begin gap_pct = 49; stall_pct <= 0;  end
        2:       begin gap_pct = 0;  stall_pct <= 49; end
        default: begin gap_pct = 32; stall_pct <= 32; end
      endcase
      if (p == 0) begin
        // a few reads under the reset settings first
        load_settings({1'b0, WINDOW_SIZE_RST}, {1'b0, STEP_SIZE_RST}, MIN_AVERAGE_RST);
        repeat (3) send_read(1 + $urandom_range(2 * cur_win + 8));
      end
      for (int unsigned goal = items_sent + PHASE_ITEMS; items_sent < goal; ) begin
        random_settings();
        repeat ($urandom_range(2, 6)) begin
          send_read(1 + $urandom_range(2 * cur_win + 8));
          if ($urandom_range(7) == 0) settle();
        end
      end
    end

    settle();
    if (error_count == 0 && due_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
